// ===== hdl/hct_pkg.sv =====
package hct_pkg;

    localparam int unsigned HW        = 16;   // height / position width, Q4.12
    localparam int unsigned NW        = 36;   // normal width, Q12.24
    localparam int unsigned CNT_CFG_W = 11;   // columns / rows register width
    localparam int unsigned STEP_W    = 14;   // step register width
    localparam int unsigned CFG_DW    = 14;   // config data width (widest register)
    localparam int unsigned CFG_IW    = 2;    // config index width
    localparam int unsigned ONE_Q12   = 4096;

    localparam int unsigned VIDX_W    = 3;
    localparam logic [VIDX_W-1:0] LAST_VERTEX = 3'd5;

    localparam logic [CNT_CFG_W-1:0] COLUMNS_RST  = 11'd1024;
    localparam logic [CNT_CFG_W-1:0] ROWS_RST     = 11'd1024;
    localparam logic [STEP_W-1:0]    COL_STEP_RST = 14'd8;
    localparam logic [STEP_W-1:0]    ROW_STEP_RST = 14'd8;

    typedef enum logic [CFG_IW-1:0] {
        CFG_COLUMNS  = 2'd0,
        CFG_ROWS     = 2'd1,
        CFG_COL_STEP = 2'd2,
        CFG_ROW_STEP = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [HW-1:0] here;
        logic signed [HW-1:0] right;
        logic signed [HW-1:0] up;
        logic signed [HW-1:0] diag;
    } t_heights;

    // Everything needed to emit the six vertices of one cell.
    typedef struct packed {
        logic signed [HW-1:0] x0;
        logic signed [HW-1:0] x1;
        logic signed [HW-1:0] y0;
        logic signed [HW-1:0] y1;
        t_heights             h;
        logic signed [NW-1:0] n1x;
        logic signed [NW-1:0] n1y;
        logic signed [NW-1:0] n2x;
        logic signed [NW-1:0] n2y;
        logic signed [NW-1:0] nz;
        logic                 last_grid;
    } t_cell_res;

endpackage

// ===== hdl/hct_cell_if.sv =====
interface hct_cell_if;
    import hct_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [HW-1:0] height_here;
    logic signed [HW-1:0] height_right;
    logic signed [HW-1:0] height_up;
    logic signed [HW-1:0] height_diag;

    modport source (
        output valid, height_here, height_right, height_up, height_diag,
        input  ready
    );
    modport sink (
        input  valid, height_here, height_right, height_up, height_diag,
        output ready
    );
endinterface

// ===== hdl/hct_vertex_if.sv =====
interface hct_vertex_if;
    import hct_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [HW-1:0] pos_x;
    logic signed [HW-1:0] pos_y;
    logic signed [HW-1:0] pos_z;
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;
    logic signed [NW-1:0] normal_z;
    logic                 last_of_cell;
    logic                 last_of_grid;

    modport source (
        output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
               last_of_cell, last_of_grid,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
               last_of_cell, last_of_grid,
        output ready
    );
endinterface

// ===== hdl/hct_grid_cursor.sv =====
module hct_grid_cursor import hct_pkg::*; #(
    parameter int unsigned MAX_COLUMNS = 1024,
    parameter int unsigned MAX_ROWS    = 1024,
    parameter int unsigned CW          = 10,
    parameter int unsigned RW          = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [CNT_CFG_W-1:0] i_columns,
    input  logic [CNT_CFG_W-1:0] i_rows,
    output logic [CW-1:0]        o_col,
    output logic [RW-1:0]        o_row,
    output logic                 o_last_grid
);

    localparam int unsigned CCW = (CW + 1 > CNT_CFG_W) ? CW + 1 : CNT_CFG_W;
    localparam int unsigned RCW = (RW + 1 > CNT_CFG_W) ? RW + 1 : CNT_CFG_W;
    localparam logic [CW-1:0] COL_END = CW'(MAX_COLUMNS - 1);
    localparam logic [RW-1:0] ROW_END = RW'(MAX_ROWS - 1);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW:0]   col_p1;
    logic [RW:0]   row_p1;
    logic          last_col, last_row;

    // a count register of zero behaves like one: the compare is always true
    assign col_p1   = {1'b0, r_col} + (CW+1)'(1);
    assign row_p1   = {1'b0, r_row} + (RW+1)'(1);
    assign last_col = (CCW'(col_p1) >= CCW'(i_columns)) || (r_col == COL_END);
    assign last_row = (RCW'(row_p1) >= RCW'(i_rows))    || (r_row == ROW_END);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : row_p1[RW-1:0];
            end else begin
                n_col = col_p1[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col       = r_col;
    assign o_row       = r_row;
    assign o_last_grid = last_col && last_row;

endmodule

// ===== hdl/hct_cell_math.sv =====
module hct_cell_math import hct_pkg::*; #(
    parameter int unsigned CW = 10,
    parameter int unsigned RW = 10
) (
    input  t_heights          i_h,
    input  logic [CW-1:0]     i_col,
    input  logic [RW-1:0]     i_row,
    input  logic [STEP_W-1:0] i_col_step,
    input  logic [STEP_W-1:0] i_row_step,
    input  logic              i_last_grid,
    output t_cell_res         o_res
);

    // exact coordinate width: count*step plus sign and the step add
    localparam int unsigned MW = (CW > RW) ? CW : RW;
    localparam int unsigned PW = MW + STEP_W + 2;
    localparam logic signed [PW-1:0] ONE    = PW'(ONE_Q12);
    localparam logic signed [PW-1:0] SAT_HI = PW'(32767);
    localparam logic signed [PW-1:0] SAT_LO = -PW'(32768);

    function automatic logic signed [HW-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [HW-1:0] r;
        if (v > SAT_HI)      r = 16'sh7fff;
        else if (v < SAT_LO) r = 16'sh8000;
        else                 r = v[HW-1:0];
        return r;
    endfunction

    logic [CW+STEP_W-1:0]   xprod;
    logic [RW+STEP_W-1:0]   yprod;
    logic signed [PW-1:0]   x0, x1, y0, y1;
    logic signed [HW:0]     d01, d02, d23, d13;
    logic signed [STEP_W:0] cs, rs;
    logic signed [31:0]     p1x, p1y, p2x, p2y;
    logic [2*STEP_W-1:0]    pz;

    assign xprod = (CW+STEP_W)'(i_col) * (CW+STEP_W)'(i_col_step);
    assign yprod = (RW+STEP_W)'(i_row) * (RW+STEP_W)'(i_row_step);
    assign x0    = $signed(PW'(xprod)) - ONE;
    assign y0    = $signed(PW'(yprod)) - ONE;
    assign x1    = x0 + $signed(PW'(i_col_step));
    assign y1    = y0 + $signed(PW'(i_row_step));

    // Triangle one edges: ab = (cs,0,h1-h0), ac = (0,rs,h2-h0).
    // Triangle two edges: ab = (-cs,0,h2-h3), ac = (0,-rs,h1-h3).
    assign d01 = $signed({i_h.here[HW-1], i_h.here})   - $signed({i_h.right[HW-1], i_h.right});
    assign d02 = $signed({i_h.here[HW-1], i_h.here})   - $signed({i_h.up[HW-1], i_h.up});
    assign d23 = $signed({i_h.up[HW-1], i_h.up})       - $signed({i_h.diag[HW-1], i_h.diag});
    assign d13 = $signed({i_h.right[HW-1], i_h.right}) - $signed({i_h.diag[HW-1], i_h.diag});
    assign cs  = $signed({1'b0, i_col_step});
    assign rs  = $signed({1'b0, i_row_step});

    assign p1x = 32'(d01 * rs);
    assign p1y = 32'(d02 * cs);
    assign p2x = 32'(d23 * rs);
    assign p2y = 32'(d13 * cs);
    assign pz  = (2*STEP_W)'(i_col_step) * (2*STEP_W)'(i_row_step);

    always_comb begin
        o_res.x0        = sat(x0);
        o_res.x1        = sat(x1);
        o_res.y0        = sat(y0);
        o_res.y1        = sat(y1);
        o_res.h         = i_h;
        o_res.n1x       = NW'(p1x);
        o_res.n1y       = NW'(p1y);
        o_res.n2x       = NW'(p2x);
        o_res.n2y       = NW'(p2y);
        o_res.nz        = $signed(NW'(pz));
        o_res.last_grid = i_last_grid;
    end

endmodule

// ===== hdl/hct_vertex_seq.sv =====
module hct_vertex_seq import hct_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_cell_res         i_res,
    output logic              o_load_ready,
    hct_vertex_if.source      o_vertex
);

    t_cell_res         r_res;
    logic              r_valid;
    logic [VIDX_W-1:0] r_vidx;
    logic              take, take_last;

    assign take         = r_valid && o_vertex.ready;
    assign take_last    = take && (r_vidx == LAST_VERTEX);
    assign o_load_ready = !r_valid || take_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_vidx  <= '0;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
                r_vidx  <= '0;
            end else if (take_last) begin
                r_valid <= 1'b0;
                r_vidx  <= '0;
            end else if (take) begin
                r_vidx  <= r_vidx + VIDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    // vertex order: t1 = here, right, up; t2 = diag, up, right
    always_comb begin
        o_vertex.pos_x    = r_res.x0;
        o_vertex.pos_y    = r_res.y0;
        o_vertex.pos_z    = r_res.h.here;
        o_vertex.normal_x = r_res.n1x;
        o_vertex.normal_y = r_res.n1y;
        case (r_vidx)
            3'd0: begin
                o_vertex.pos_x = r_res.x0;
                o_vertex.pos_y = r_res.y0;
                o_vertex.pos_z = r_res.h.here;
            end
            3'd1: begin
                o_vertex.pos_x = r_res.x1;
                o_vertex.pos_y = r_res.y0;
                o_vertex.pos_z = r_res.h.right;
            end
            3'd2: begin
                o_vertex.pos_x = r_res.x0;
                o_vertex.pos_y = r_res.y1;
                o_vertex.pos_z = r_res.h.up;
            end
            3'd3: begin
                o_vertex.pos_x    = r_res.x1;
                o_vertex.pos_y    = r_res.y1;
                o_vertex.pos_z    = r_res.h.diag;
                o_vertex.normal_x = r_res.n2x;
                o_vertex.normal_y = r_res.n2y;
            end
            3'd4: begin
                o_vertex.pos_x    = r_res.x0;
                o_vertex.pos_y    = r_res.y1;
                o_vertex.pos_z    = r_res.h.up;
                o_vertex.normal_x = r_res.n2x;
                o_vertex.normal_y = r_res.n2y;
            end
            3'd5: begin
                o_vertex.pos_x    = r_res.x1;
                o_vertex.pos_y    = r_res.y0;
                o_vertex.pos_z    = r_res.h.right;
                o_vertex.normal_x = r_res.n2x;
                o_vertex.normal_y = r_res.n2y;
            end
            default: begin
                o_vertex.pos_x = r_res.x0;
            end
        endcase
    end

    assign o_vertex.valid        = r_valid;
    assign o_vertex.normal_z     = r_res.nz;
    assign o_vertex.last_of_cell = (r_vidx == LAST_VERTEX);
    assign o_vertex.last_of_grid = (r_vidx == LAST_VERTEX) && r_res.last_grid;

    a_vidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vidx <= LAST_VERTEX)
        else $error("vertex index past last vertex");

    a_idle_vidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> r_vidx == '0)
        else $error("vertex index not parked while empty");

    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid && r_vidx == '0)
        else $error("load did not start a new cell at vertex zero");

    a_load_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && !take_last |-> !r_valid)
        else $error("cell overwritten before its last vertex left");

endmodule

// ===== hdl/heightmap_cell_triangulator.sv =====
// Heightmap cell triangulator. Each input word carries the four corner
// heights of one grid cell (signed Q4.12) in row-major order; internal column
// and row counters track where that cell sits. For every cell the block emits
// six vertex words: triangle one (here, right, up) and triangle two (diag, up,
// right). Each vertex has x = col*column_step - 1.0, y = row*row_step - 1.0
// (saturated to 16 bits), z = corner height, and its triangle's face normal
// (ab x ac) in exact Q12.24, computed from unsaturated edges. last_of_cell
// marks the sixth vertex, last_of_grid the sixth vertex of the final cell,
// after which the counters wrap to zero. Registers: 0 columns, 1 rows,
// 2 column_step, 3 row_step; write them only while the block is idle.
// Cell throughput is set by the single vertex output channel carrying six
// words per cell. An accepted cell passes through the input register, then
// the math stage into the cell result register, before its first vertex
// goes out. A new cell is taken while the previous one is still draining,
// so the output streams without gaps.
module heightmap_cell_triangulator import hct_pkg::*; #(
    parameter int unsigned MAX_COLUMNS = 1024,
    parameter int unsigned MAX_ROWS    = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    hct_cell_if.sink          i_cell,
    hct_vertex_if.source      o_vertex
);

    // counter widths follow the grid limits
    localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int unsigned RW = (MAX_ROWS > 1)    ? $clog2(MAX_ROWS)    : 1;

    // configuration
    logic [CNT_CFG_W-1:0] r_columns, r_rows;
    logic [STEP_W-1:0]    r_col_step, r_row_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns  <= COLUMNS_RST;
            r_rows     <= ROWS_RST;
            r_col_step <= COL_STEP_RST;
            r_row_step <= ROW_STEP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COLUMNS:  r_columns  <= i_cfg_data[CNT_CFG_W-1:0];
                CFG_ROWS:     r_rows     <= i_cfg_data[CNT_CFG_W-1:0];
                CFG_COL_STEP: r_col_step <= i_cfg_data[STEP_W-1:0];
                CFG_ROW_STEP: r_row_step <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input acceptance and cell position
    logic          accept, seq_ready, load;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic          cur_last_grid;

    assign accept = i_cell.valid && i_cell.ready;

    hct_grid_cursor #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .CW          (CW),
        .RW          (RW)
    ) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (accept),
        .i_columns   (r_columns),
        .i_rows      (r_rows),
        .o_col       (cur_col),
        .o_row       (cur_row),
        .o_last_grid (cur_last_grid)
    );

    // input register: heights plus the cell's position snapshot
    logic          r_in_valid;
    t_heights      r_h;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_last_grid;

    // the input stage empties whenever the result register can take its cell
    assign i_cell.ready = !r_in_valid || seq_ready;
    assign load         = r_in_valid && seq_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (seq_ready) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_h.here    <= i_cell.height_here;
            r_h.right   <= i_cell.height_right;
            r_h.up      <= i_cell.height_up;
            r_h.diag    <= i_cell.height_diag;
            r_col       <= cur_col;
            r_row       <= cur_row;
            r_last_grid <= cur_last_grid;
        end
    end

    // positions and normals
    t_cell_res cell_res;

    hct_cell_math #(
        .CW (CW),
        .RW (RW)
    ) u_math (
        .i_h         (r_h),
        .i_col       (r_col),
        .i_row       (r_row),
        .i_col_step  (r_col_step),
        .i_row_step  (r_row_step),
        .i_last_grid (r_last_grid),
        .o_res       (cell_res)
    );

    // result register and six-word vertex sequencer
    hct_vertex_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_res        (cell_res),
        .o_load_ready (seq_ready),
        .o_vertex     (o_vertex)
    );

endmodule

// ===== sim/heightmap_cell_triangulator_tb.sv =====
`timescale 1ns / 1ps

module heightmap_cell_triangulator_tb;
    import hct_pkg::*;

    // Grid limits handed to the DUT; the predictor clamps its counters the same way.
    localparam int unsigned MAX_CELL_COLUMNS = 1024;
    localparam int unsigned MAX_CELL_ROWS    = 1024;

    // One vertex word as it leaves the block.
    typedef struct packed {
        logic signed [HW-1:0] pos_x;
        logic signed [HW-1:0] pos_y;
        logic signed [HW-1:0] pos_z;
        logic signed [NW-1:0] normal_x;
        logic signed [NW-1:0] normal_y;
        logic signed [NW-1:0] normal_z;
        logic                 last_of_cell;
        logic                 last_of_grid;
    } t_vertex;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    t_cfg_idx          i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    hct_cell_if   cell_bus();
    hct_vertex_if vertex_bus();

    heightmap_cell_triangulator #(
        .MAX_COLUMNS(MAX_CELL_COLUMNS),
        .MAX_ROWS   (MAX_CELL_ROWS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_cell    (cell_bus),
        .o_vertex  (vertex_bus)
    );

    // Predictor's copy of the registers and the grid position.
    logic [CNT_CFG_W-1:0] cfg_columns  = COLUMNS_RST;
    logic [CNT_CFG_W-1:0] cfg_rows     = ROWS_RST;
    logic [STEP_W-1:0]    cfg_col_step = COL_STEP_RST;
    logic [STEP_W-1:0]    cfg_row_step = ROW_STEP_RST;
    int                   grid_col     = 0;
    int                   grid_row     = 0;

    // Vertices the block still owes us, oldest first.
    t_vertex expected_vertices[$];
    t_vertex want_vertex;
    t_vertex got_vertex;

    int error_count = 0;
    int idle_pct    = 0;   // chance per cycle that the sender holds back
    int stall_pct   = 0;   // chance per cycle that the receiver drops ready
    int hold_cycles = 0;   // long receiver hold-off, counted down below

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic signed [HW-1:0] sat_q12(input longint v);
        longint c;
        c = v;
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        return c[HW-1:0];
    endfunction

    // Queue three vertices of triangle (a, b, c); normal = (b - a) x (c - a),
    // taken from the unsaturated positions so it stays exact.
    task automatic push_triangle(input longint ax, ay, az, bx, by, bz, cx, cy, cz,
                                 input bit closes_cell, input bit closes_grid);
        longint  px[3];
        longint  py[3];
        longint  pz[3];
        longint  ux, uy, uz, wx, wy, wz, nx, ny, nz, zk;
        t_vertex v;
        px[0] = ax; px[1] = bx; px[2] = cx;
        py[0] = ay; py[1] = by; py[2] = cy;
        pz[0] = az; pz[1] = bz; pz[2] = cz;
        ux = bx - ax; uy = by - ay; uz = bz - az;
        wx = cx - ax; wy = cy - ay; wz = cz - az;
        nx = uy * wz - uz * wy;
        ny = uz * wx - ux * wz;
        nz = ux * wy - uy * wx;
        for (int k = 0; k < 3; k++) begin
            zk             = pz[k];
            v.pos_x        = sat_q12(px[k]);
            v.pos_y        = sat_q12(py[k]);
            v.pos_z        = zk[HW-1:0];
            v.normal_x     = nx[NW-1:0];
            v.normal_y     = ny[NW-1:0];
            v.normal_z     = nz[NW-1:0];
            v.last_of_cell = closes_cell && (k == 2);
            v.last_of_grid = closes_grid && (k == 2);
            expected_vertices.push_back(v);
        end
    endtask

    // Work out the six vertices of one accepted cell, then step the grid.
    task automatic triangulate_cell(input t_heights h);
        longint x0, x1, y0, y1, h0, h1, h2, h3;
        bit     last_col, last_row;
        h0 = $signed(h.here);
        h1 = $signed(h.right);
        h2 = $signed(h.up);
        h3 = $signed(h.diag);
        x0 = longint'(grid_col) * longint'(cfg_col_step) - longint'(ONE_Q12);
        x1 = x0 + longint'(cfg_col_step);
        y0 = longint'(grid_row) * longint'(cfg_row_step) - longint'(ONE_Q12);
        y1 = y0 + longint'(cfg_row_step);
        // a count of zero wraps every cell, same as one
        last_col = (grid_col + 1 >= cfg_columns) || (grid_col + 1 >= MAX_CELL_COLUMNS);
        last_row = (grid_row + 1 >= cfg_rows) || (grid_row + 1 >= MAX_CELL_ROWS);

        push_triangle(x0, y0, h0, x1, y0, h1, x0, y1, h2, 1'b0, 1'b0);
        push_triangle(x1, y1, h3, x0, y1, h2, x1, y0, h1, 1'b1, last_col && last_row);

        if (last_col) begin
            grid_col = 0;
            grid_row = last_row ? 0 : grid_row + 1;
        end else begin
            grid_col++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [HW-1:0] rand_height();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return r[HW-1:0];
        endcase
    endfunction

    function automatic t_heights rand_heights();
        t_heights h;
        h.here  = rand_height();
        h.right = rand_height();
        h.up    = rand_height();
        h.diag  = rand_height();
        return h;
    endfunction

    function automatic logic [CFG_DW-1:0] rand_step();
        case ($urandom_range(3))
            0:       return CFG_DW'($urandom_range(0, 16383));
            1:       return CFG_DW'(8192);
            2:       return CFG_DW'($urandom_range(1, 64));
            default: return CFG_DW'(16383);
        endcase
    endfunction

    // Offer one cell word and wait for it to be taken. Valid is left high on
    // return so back-to-back words need no extra edge; only a gap lowers it.
    task automatic send_cell(input t_heights h);
        if ($urandom_range(99) < idle_pct) begin
            cell_bus.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        cell_bus.valid        <= 1'b1;
        cell_bus.height_here  <= h.here;
        cell_bus.height_right <= h.right;
        cell_bus.height_up    <= h.up;
        cell_bus.height_diag  <= h.diag;
        @(posedge i_clk);
        while (!cell_bus.ready) @(posedge i_clk);
        triangulate_cell(h);
    endtask

    task automatic send_random_cells(input int count);
        for (int n = 0; n < count; n++) send_cell(rand_heights());
    endtask

    // Stop offering and wait for every owed vertex, plus the pipe latency.
    task automatic wait_idle();
        cell_bus.valid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Leaves the write enable high; write_config lowers it after the last one.
    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_COLUMNS:  cfg_columns  = data[CNT_CFG_W-1:0];
            CFG_ROWS:     cfg_rows     = data[CNT_CFG_W-1:0];
            CFG_COL_STEP: cfg_col_step = data[STEP_W-1:0];
            CFG_ROW_STEP: cfg_row_step = data[STEP_W-1:0];
            default: begin
            end
        endcase
    endtask

    // Counters are not touched by a register write; the grid carries on.
    task automatic write_config(input logic [CFG_DW-1:0] cols, rws, col_step, row_step);
        wait_idle();
        write_register(CFG_COLUMNS, cols);
        write_register(CFG_ROWS, rws);
        write_register(CFG_COL_STEP, col_step);
        write_register(CFG_ROW_STEP, row_step);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values of the registers, extreme corner heights (here, right, up, diag).
    task automatic test_reset_corners();
        send_cell({16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
        send_cell({16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        send_cell({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        send_cell({16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF});
        send_cell({16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000});
    endtask

    task automatic test_register_extremes();
        // zero counts act as one, zero steps pin every position at -1.0
        write_config(0, 0, 0, 0);
        send_random_cells(2);
        // one-cell grid, widest steps
        write_config(1, 1, 16383, 16383);
        send_random_cells(2);
        // 3 x 2 grid walked through once, then wraps to the origin
        write_config(3, 2, 8192, 1);
        send_random_cells(6);
        // bits above the 11-bit count are dropped (columns = 3); positions saturate
        write_config(14'h3803, 3, 16383, 16383);
        send_random_cells(9);
    endtask

    // A count above the instance limit keeps the column counter running;
    // x saturates after a few cells.
    task automatic test_wide_row();
        write_config(2047, 2047, 8192, 8192);
        idle_pct  = 0;
        stall_pct = 0;
        send_random_cells(12);
    endtask

    // Each idling mix runs on its own random grid.
    task automatic test_idle_phases();
        int sender_idle[4]   = '{0, 84, 0, 15};
        int receiver_idle[4] = '{0, 0, 84, 15};
        logic [CFG_DW-1:0] cols, rws;
        for (int p = 0; p < 4; p++) begin
            case ($urandom_range(9))
                0:       cols = 0;
                1:       cols = 1024;
                default: cols = CFG_DW'($urandom_range(1, 6));
            endcase
            case ($urandom_range(9))
                0:       rws = 1024;
                1:       rws = 2047;
                default: rws = CFG_DW'($urandom_range(1, 4));
            endcase
            write_config(cols, rws, rand_step(), rand_step());
            idle_pct  = sender_idle[p];
            stall_pct = receiver_idle[p];
            send_random_cells(25);
        end
    endtask

    // Receiver holds off while the sender keeps pushing: the block fills and
    // stalls its input. Then the sender pauses until everything has drained.
    task automatic test_backpressure();
        write_config(4, 3, 8192, 8192);
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 300;
        send_random_cells(12);
        wait_idle();
        idle_pct  = 15;
        stall_pct = 15;
        send_random_cells(8);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            vertex_bus.ready <= 1'b0;
            hold_cycles--;
        end else begin
            vertex_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && vertex_bus.valid && vertex_bus.ready) begin
            got_vertex.pos_x        = vertex_bus.pos_x;
            got_vertex.pos_y        = vertex_bus.pos_y;
            got_vertex.pos_z        = vertex_bus.pos_z;
            got_vertex.normal_x     = vertex_bus.normal_x;
            got_vertex.normal_y     = vertex_bus.normal_y;
            got_vertex.normal_z     = vertex_bus.normal_z;
            got_vertex.last_of_cell = vertex_bus.last_of_cell;
            got_vertex.last_of_grid = vertex_bus.last_of_grid;
            if (expected_vertices.size() == 0) begin
                flag_mismatch("vertex word with nothing expected");
            end else begin
                want_vertex = expected_vertices.pop_front();
                if (got_vertex.pos_x !== want_vertex.pos_x)
                    flag_mismatch($sformatf("pos_x got %h want %h",
                                            got_vertex.pos_x, want_vertex.pos_x));
                if (got_vertex.pos_y !== want_vertex.pos_y)
                    flag_mismatch($sformatf("pos_y got %h want %h",
                                            got_vertex.pos_y, want_vertex.pos_y));
                if (got_vertex.pos_z !== want_vertex.pos_z)
                    flag_mismatch($sformatf("pos_z got %h want %h",
                                            got_vertex.pos_z, want_vertex.pos_z));
                if (got_vertex.normal_x !== want_vertex.normal_x)
                    flag_mismatch($sformatf("normal_x got %h want %h",
                                            got_vertex.normal_x, want_vertex.normal_x));
                if (got_vertex.normal_y !== want_vertex.normal_y)
                    flag_mismatch($sformatf("normal_y got %h want %h",
                                            got_vertex.normal_y, want_vertex.normal_y));
                if (got_vertex.normal_z !== want_vertex.normal_z)
                    flag_mismatch($sformatf("normal_z got %h want %h",
                                            got_vertex.normal_z, want_vertex.normal_z));
                if (got_vertex.last_of_cell !== want_vertex.last_of_cell)
                    flag_mismatch($sformatf("last_of_cell got %b want %b",
                                            got_vertex.last_of_cell, want_vertex.last_of_cell));
                if (got_vertex.last_of_grid !== want_vertex.last_of_grid)
                    flag_mismatch($sformatf("last_of_grid got %b want %b",
                                            got_vertex.last_of_grid, want_vertex.last_of_grid));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_COLUMNS;
        i_cfg_data            = '0;
        cell_bus.valid        = 1'b0;
        cell_bus.height_here  = '0;
        cell_bus.height_right = '0;
        cell_bus.height_up    = '0;
        cell_bus.height_diag  = '0;
        vertex_bus.ready      = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_corners();
        test_register_extremes();
        test_wide_row();
        test_idle_phases();
        test_backpressure();

        wait_idle();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/hct_pkg.sv
hdl/hct_cell_if.sv
hdl/hct_vertex_if.sv
hdl/hct_grid_cursor.sv
hdl/hct_cell_math.sv
hdl/hct_vertex_seq.sv
hdl/heightmap_cell_triangulator.sv
sim/heightmap_cell_triangulator_tb.sv
